// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros used by the controller unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	`ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// File: hw/rtl/pivi_pkg.sv
// ----------------------------------------------------------------------------
// pivi_pkg
// types, constants and helpers of the incremental pi controller
// ----------------------------------------------------------------------------
package pivi_pkg;

	localparam int DIV_NW = 48;
	localparam int DIV_DW = 33;
	localparam int DIV_CW = 6;

	localparam logic [2:0] REG_SETPOINT  = 3'd0;
	localparam logic [2:0] REG_OUT_MIN   = 3'd1;
	localparam logic [2:0] REG_OUT_MAX   = 3'd2;
	localparam logic [2:0] REG_GAIN_PROP = 3'd3;
	localparam logic [2:0] REG_GAIN_INT  = 3'd4;

	localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
	localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

	localparam logic [16:0] FACTOR_ONE = 17'd65536;

	// reciprocal of 5 scaled by 2^34, exact for every 32-bit operand
	localparam logic [31:0] DIV5_MAGIC = 32'hCCCCCCCD;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_SPAN,
		ST_DBAND,
		ST_FACTOR,
		ST_F_GO,
		ST_F_WAIT,
		ST_MUL_P,
		ST_MUL_T,
		ST_MUL_I,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) r = 32'sh7FFFFFFF;
		else if (v < SAT_MIN) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [29:0] div5(input logic [31:0] x);
		logic [63:0] prod;
		prod = {32'd0, x} * {32'd0, DIV5_MAGIC};
		return prod[63:34];
	endfunction

endpackage

// File: hw/rtl/pivi_if.sv
// ----------------------------------------------------------------------------
// pivi_if
// handshake channels of the controller: sample in, drive out, register write
// ----------------------------------------------------------------------------
interface pivi_freq_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured_freq;
	modport source (output valid, output measured_freq, input ready);
	modport sink (input valid, input measured_freq, output ready);
endinterface

interface pivi_drive_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive_value;
	modport source (output valid, output drive_value, input ready);
	modport sink (input valid, input drive_value, output ready);
endinterface

interface pivi_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hw/rtl/incremental_pi_variable_integral_unit.sv
// steps from input accept to drive item valid: PREP, SPAN, DBAND (skipped with inverted
// limits), FACTOR, F_GO and F_WAIT on the divider (skipped when the integral factor is 0 or 1),
// MUL_P, MUL_T, MUL_I, FIN; one item in flight: the next input is accepted only in ST_IDLE,
// reentered as the drive item is registered, and FIN holds while the previous drive item is held off
// reset: setpoint 0, out_min 0, out_max 100.0, gains 1229 and 1434,
// stored error and held output cleared, no item pending
// ----------------------------------------------------------------------------
// incremental_pi_variable_integral_unit
// incremental pi controller with variable integral factor and deadband
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module incremental_pi_variable_integral_unit
	import pivi_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pivi_freq_if.sink     freq,
	pivi_drive_if.source  drive,
	pivi_cfg_if.sink      cfg
);

	state_t state_q, state_d;

	logic signed [31:0] setpoint_q, out_min_q, out_max_q, prev_err_q, held_q;
	logic [15:0]        gain_prop_q, gain_int_q;
	logic signed [31:0] meas_q, flow_q, err_q, ediff_q, p_q;
	logic [31:0]        aerr_q, amin_q, amax_q, dband_q;
	logic signed [32:0] span_q;
	logic [16:0]        factor_q;
	logic signed [50:0] prod_q;
	logic               out_valid_q;
	logic signed [31:0] drive_q;

	logic               div_start;
	logic [DIV_NW-1:0]  div_num, div_quot;
	logic [DIV_DW-1:0]  div_den;
	div_stat_t          div_st;

	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [35:0] m36;
	logic signed [31:0] flow_c, err_c, i_c, inc_c, base_c, res_c;
	logic               span_neg, in_db, near_min, out_free;
	logic signed [32:0] sp_d, fl_d;
	logic [32:0]        sp_a, fl_a;
	logic [31:0]        q5_in, amax_c;
	logic [29:0]        q5;
	logic [2:0]         r5;

	assign freq.ready  = state_q == ST_IDLE;
	assign cfg.ready   = 1'b1;
	assign drive.valid = out_valid_q;
	assign drive.drive_value = drive_q;
	assign out_free    = !out_valid_q || drive.ready;
	assign span_neg    = span_q[32];

	pivi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quot     (div_quot),
		.stat     (div_st)
	);

	// front end arithmetic
	assign m36    = ({{4{meas_q[31]}}, meas_q} <<< 4) - {{4{meas_q[31]}}, meas_q};
	assign flow_c = sat32(52'(m36 >>> 1));
	assign err_c  = sat32(52'(setpoint_q) - 52'(flow_c));

	// divide by 5 by reciprocal, shared by the span and deadband steps
	assign q5_in  = (state_q == ST_DBAND) ? (amin_q >> 3) : span_q[31:0];
	assign q5     = div5(q5_in);
	assign r5     = 3'(q5_in - {q5, 2'b00} - {2'b00, q5});
	assign amax_c = {q5, 2'b00}
		+ ((r5 == 3'd0) ? 32'd0 : 32'(r5 - 3'd1));

	// shared multiplier operands
	always_comb begin
		case (state_q)
			ST_MUL_P: begin
				mul_a = {2'b00, gain_prop_q};
				mul_b = 33'(ediff_q);
			end
			ST_MUL_T: begin
				mul_a = {1'b0, factor_q};
				mul_b = 33'(err_q);
			end
			default: begin
				mul_a = {2'b00, gain_int_q};
				mul_b = prod_q[48:16];
			end
		endcase
	end

	// output stage arithmetic
	assign in_db    = !span_neg && (aerr_q <= dband_q);
	assign sp_d     = 33'(setpoint_q) - 33'(out_min_q);
	assign fl_d     = 33'(flow_q) - 33'(out_min_q);
	assign sp_a     = sp_d[32] ? 33'(-sp_d) : sp_d;
	assign fl_a     = fl_d[32] ? 33'(-fl_d) : fl_d;
	assign near_min = (sp_a < {1'b0, dband_q}) && (fl_a < {1'b0, dband_q});
	assign i_c      = sat32(52'(prod_q >>> 12));
	assign inc_c    = in_db ? 32'sd0 : sat32(52'(p_q) + 52'(i_c));
	assign base_c   = (in_db && near_min) ? out_min_q : held_q;

	always_comb begin
		res_c = sat32(52'(base_c) + 52'(inc_c));
		if (res_c >= out_max_q) res_c = out_max_q;
		if (res_c <= out_min_q) res_c = out_min_q;
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = {amax_q - aerr_q, 16'h0000};
		div_den   = 33'(amax_q) - 33'(amin_q);
		unique case (state_q)
			ST_IDLE:   if (freq.valid) state_d = ST_PREP;
			ST_PREP:   state_d = ST_SPAN;
			ST_SPAN:   state_d = span_neg ? ST_FACTOR : ST_DBAND;
			ST_DBAND:  state_d = ST_FACTOR;
			ST_FACTOR: begin
				if (span_neg || aerr_q <= amin_q || aerr_q > amax_q) state_d = ST_MUL_P;
				else state_d = ST_F_GO;
			end
			ST_F_GO: begin
				div_start = 1'b1;
				state_d   = ST_F_WAIT;
			end
			ST_F_WAIT: if (div_st.done) state_d = ST_MUL_P;
			ST_MUL_P:  state_d = ST_MUL_T;
			ST_MUL_T:  state_d = ST_MUL_I;
			ST_MUL_I:  state_d = ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// registers, held state and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= 32'sd0;
			out_min_q   <= 32'sd0;
			out_max_q   <= 32'sd6553600;
			gain_prop_q <= 16'd1229;
			gain_int_q  <= 16'd1434;
			prev_err_q  <= 32'sd0;
			held_q      <= 32'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_SETPOINT:  setpoint_q <= cfg.wdata;
					REG_OUT_MIN: begin
						out_min_q  <= cfg.wdata;
						held_q     <= cfg.wdata;
						prev_err_q <= 32'sd0;
					end
					REG_OUT_MAX:   out_max_q <= cfg.wdata;
					REG_GAIN_PROP: gain_prop_q <= cfg.wdata[15:0];
					REG_GAIN_INT:  gain_int_q <= cfg.wdata[15:0];
					default: ;
				endcase
			end
			if (state_q == ST_FIN && out_free) begin
				prev_err_q  <= err_q;
				held_q      <= res_c;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (freq.valid && freq.ready) meas_q <= freq.measured_freq;
		if (state_q == ST_FIN && out_free) drive_q <= res_c;
		case (state_q)
			ST_PREP: begin
				flow_q <= flow_c;
				err_q  <= err_c;
				aerr_q <= err_c[31] ? 32'(-33'(err_c)) : 32'(err_c);
				span_q <= 33'(out_max_q) - 33'(out_min_q);
			end
			ST_SPAN: begin
				amin_q <= {2'b00, q5};
				amax_q <= amax_c;
			end
			ST_DBAND: dband_q <= {2'b00, q5};
			ST_FACTOR: begin
				ediff_q <= sat32(52'(err_q) - 52'(prev_err_q));
				if (span_neg || aerr_q > amax_q) factor_q <= 17'd0;
				else if (aerr_q <= amin_q) factor_q <= FACTOR_ONE;
			end
			ST_F_WAIT: factor_q <= div_quot[16:0];
			ST_MUL_P:  prod_q <= 51'(mul_a * mul_b);
			ST_MUL_T: begin
				p_q    <= sat32(52'(prod_q >>> 12));
				prod_q <= 51'(mul_a * mul_b);
			end
			ST_MUL_I:  prod_q <= 51'(mul_a * mul_b);
			default: ;
		endcase
	end

	`ASSERT_CLK(a_factor_range, clk, arst_n, (state_q == ST_MUL_P) |-> (factor_q <= FACTOR_ONE), "integral factor above one")
	`ASSERT_ALWAYS(a_div_done_wait, clk, arst_n, div_st.done |-> (state_q == ST_F_WAIT), "divider done outside a wait step")
	`ASSERT_CLK(a_drive_clamped, clk, arst_n, (out_valid_q && out_min_q <= out_max_q) |-> (drive_q >= out_min_q && drive_q <= out_max_q), "drive value outside limits")

endmodule

// File: hw/rtl/pivi_div.sv
// ----------------------------------------------------------------------------
// pivi_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pivi_div
	import pivi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic [DIV_NW-1:0] quot,
	output div_stat_t         stat
);

	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q[DIV_DW-1:0], num_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DIV_CW'(DIV_NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			num_q <= {num_q[DIV_NW-2:0], fits};
		end
	end

	assign quot      = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: tb/incremental_pi_variable_integral_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// incremental_pi_variable_integral_unit_test
// Self-checking bench for the incremental pi controller. Frequency samples
// go in through a queue-fed driver. A monitor checks each drive value
// against an in-bench model of the controller, which keeps its own copy
// of the registers, the stored error and the held output. Runs step
// through several register settings: the defaults, inverted and extreme
// limits, zero and full-scale gains, and random settings.
// ----------------------------------------------------------------------------
module incremental_pi_variable_integral_unit_test
	import pivi_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES  = 250;

	logic clk;
	logic arst_n;

	pivi_freq_if  fi ();
	pivi_drive_if dr ();
	pivi_cfg_if   cf ();

	incremental_pi_variable_integral_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.freq   (fi.sink),
		.drive  (dr.source),
		.cfg    (cf.sink)
	);

	// controller model state
	longint m_setpoint, m_out_min, m_out_max, m_kp, m_ki, m_prev_err, m_held;

	logic signed [31:0] pending_freq[$];
	logic signed [31:0] expected_drive[$];
	int errors;
	int results_seen;
	int idle_on;
	int send_gap;
	int recv_gap;
	int hold_left;
	int stall_cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_div(input longint v, input longint d);
		longint q;
		q = v / d;
		if ((v % d) != 0 && v < 0) q = q - 1;
		return q;
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic signed [31:0] next_drive(input logic signed [31:0] freq);
		longint flow, err, aerr, span, amax, amin, dband, factor, inc, res, p, t, iv;
		flow  = clip32(floor_div(longint'(freq) * 15, 2));
		err   = clip32(m_setpoint - flow);
		aerr  = mag(err);
		span  = m_out_max - m_out_min;
		amax  = floor_div(span * 4, 5);
		amin  = floor_div(span, 5);
		dband = floor_div(span, 200);
		inc   = 0;
		res   = m_held;
		if (aerr <= amin) factor = 65536;
		else if (aerr > amax) factor = 0;
		else factor = floor_div((amax - aerr) * 65536, amax - amin);
		if (aerr > dband) begin
			p   = clip32(floor_div(m_kp * clip32(err - m_prev_err), 4096));
			t   = floor_div(factor * err, 65536);
			iv  = clip32(floor_div(m_ki * t, 4096));
			inc = clip32(p + iv);
		end else if (mag(m_setpoint - m_out_min) < dband && mag(flow - m_out_min) < dband) begin
			res = m_out_min;
		end
		res = clip32(res + inc);
		if (res >= m_out_max) res = m_out_max;
		if (res <= m_out_min) res = m_out_min;
		m_prev_err = err;
		m_held     = res;
		return res[31:0];
	endfunction

	task automatic report(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi.valid         <= 1'b0;
			fi.measured_freq <= '0;
			send_gap = 0;
		end else begin
			if (fi.valid && fi.ready) begin
				expected_drive.push_back(next_drive(fi.measured_freq));
				send_gap = idle_on ? $urandom_range(0, 9) : 0;
			end
			if (!fi.valid || fi.ready) begin
				if (send_gap == 0 && pending_freq.size() > 0) begin
					fi.valid         <= 1'b1;
					fi.measured_freq <= pending_freq.pop_front();
				end else begin
					fi.valid <= 1'b0;
					if (send_gap > 0) send_gap--;
				end
			end
		end
	end

	// drive monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dr.ready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			if (dr.valid && dr.ready) begin
				if (expected_drive.size() == 0) begin
					report("unexpected item", dr.drive_value, 0);
				end else begin
					logic signed [31:0] want;
					want = expected_drive.pop_front();
					if (dr.drive_value !== want) report("drive_value", dr.drive_value, want);
				end
				results_seen++;
				recv_gap = idle_on ? $urandom_range(0, 9) : 0;
				if (results_seen == 150) hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				dr.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				dr.ready <= 1'b0;
			end else begin
				dr.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((fi.valid && fi.ready) || (dr.valid && dr.ready) || (cf.valid && cf.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cf.valid <= 1'b1;
		cf.index <= idx;
		cf.wdata <= data;
		do @(posedge clk); while (!cf.ready);
		cf.valid <= 1'b0;
		case (idx)
			REG_SETPOINT: m_setpoint = longint'(signed'(data));
			REG_OUT_MIN: begin
				m_out_min  = longint'(signed'(data));
				m_held     = m_out_min;
				m_prev_err = 0;
			end
			REG_OUT_MAX:   m_out_max = longint'(signed'(data));
			REG_GAIN_PROP: m_kp = data[15:0];
			REG_GAIN_INT:  m_ki = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [31:0] sp, input logic [31:0] mn,
			input logic [31:0] mx, input logic [15:0] kp, input logic [15:0] ki);
		write_reg(REG_SETPOINT, sp);
		write_reg(REG_OUT_MIN, mn);
		write_reg(REG_OUT_MAX, mx);
		write_reg(REG_GAIN_PROP, {16'd0, kp});
		write_reg(REG_GAIN_INT, {16'd0, ki});
	endtask

	task automatic wait_idle();
		while (pending_freq.size() > 0 || fi.valid || expected_drive.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sample whose flow lands near the setpoint, spread by a random window
	function automatic logic signed [31:0] near_setpoint();
		longint base, w, v;
		base = floor_div(m_setpoint * 2, 15);
		case ($urandom_range(0, 3))
			0: w = 16;
			1: w = 2000;
			2: w = mag(m_out_max - m_out_min) / 60 + 1;
			default: w = mag(m_out_max - m_out_min) / 8 + 1;
		endcase
		if (w > 64'd2000000000) w = 64'd2000000000;
		v = base + longint'($urandom_range(0, 2 * w)) - w;
		return 32'(clip32(v));
	endfunction

	task automatic random_phase(input int n);
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) pending_freq.push_back(near_setpoint());
			else if (pick < 9) pending_freq.push_back($urandom);
			else pending_freq.push_back($urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000);
		end
		wait_idle();
	endtask

	initial begin
		logic [31:0] mn, mx, sp;
		errors = 0;
		results_seen = 0;
		idle_on = 1;
		stall_cycles = 0;
		cf.valid = 1'b0;
		cf.index = '0;
		cf.wdata = '0;
		m_setpoint = 0; m_out_min = 0; m_out_max = 6553600;
		m_kp = 1229; m_ki = 1434; m_prev_err = 0; m_held = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: near-minimum case, extremes, mid factor
		pending_freq.push_back(32'sd0);
		pending_freq.push_back(32'sd1);
		pending_freq.push_back(-32'sd1);
		pending_freq.push_back(32'sh7FFFFFFF);
		pending_freq.push_back(32'sh80000000);
		pending_freq.push_back(32'sd0);
		pending_freq.push_back(-32'sd436906);
		pending_freq.push_back(-32'sd100000);
		wait_idle();
		set_limits(32'd3276800, 32'd0, 32'd6553600, 16'd4096, 16'd4096);
		pending_freq.push_back(32'sd436906);
		pending_freq.push_back(32'sd436900);
		pending_freq.push_back(32'sd349525);
		pending_freq.push_back(32'sd87381);
		pending_freq.push_back(32'sd0);
		wait_idle();
		// inverted limits, zero gains
		set_limits(32'd0, 32'd6553600, 32'd0, 16'd0, 16'd0);
		pending_freq.push_back(32'sd0);
		pending_freq.push_back(32'sh7FFFFFFF);
		pending_freq.push_back(32'sd100000);
		wait_idle();
		// widest span, full gains, extreme setpoints
		set_limits(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
		pending_freq.push_back(32'sh80000000);
		pending_freq.push_back(32'sh7FFFFFFF);
		pending_freq.push_back(32'sd0);
		wait_idle();
		write_reg(REG_SETPOINT, 32'h80000000);
		pending_freq.push_back(32'sh7FFFFFFF);
		pending_freq.push_back(32'sh80000000);
		pending_freq.push_back(32'sd0);
		wait_idle();

		// random settings
		for (int ph = 0; ph < 11; ph++) begin
			idle_on = (ph % 4 != 2);
			case (ph % 5)
				0: begin mn = 32'd0; mx = 32'd6553600; end
				1: begin mn = $urandom_range(0, 1000000) - 500000; mx = mn + $urandom_range(1, 20000000); end
				2: begin mn = $urandom; mx = $urandom; end
				3: begin mn = 32'h80000000; mx = 32'h7FFFFFFF; end
				default: begin mn = -$urandom_range(0, 3000000); mx = $urandom_range(0, 3000000); end
			endcase
			sp = (ph % 3 == 0) ? $urandom : mn + ((mx - mn) / 100) * $urandom_range(0, 100);
			if (ph == 6) begin
				write_reg(REG_SETPOINT, sp);
				write_reg(REG_GAIN_PROP, $urandom);
			end else begin
				set_limits(sp, mn, mx, $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192)),
					$urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192)));
			end
			random_phase(56);
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
